// File: sv/gyvi_pkg.sv
// Shared types and constants for the gyro-gated yaw variance inflator.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gyvi_pkg;

  localparam int unsigned RateW     = 24;
  localparam int unsigned VarW      = 32;
  localparam int unsigned GainW     = 16;
  localparam int unsigned DeadbandW = 23;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CmdQDepth = 2;

  // input op codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_GYRO = 2'd1;
  localparam logic [1:0] OP_ODOM = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_GAIN         = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEADBAND     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FLOOR        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CEILING      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ADJUST_TWIST = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT      = 3'd5;

  // register reset values
  localparam logic [GainW-1:0]     GainRst     = 16'd512;
  localparam logic [DeadbandW-1:0] DeadbandRst = 23'd6554;
  localparam logic [VarW-1:0]      FloorRst    = 32'd0;
  localparam logic [VarW-1:0]      CeilingRst  = 32'd65536;
  localparam logic                 AdjTwistRst = 1'b1;
  localparam logic [TimeoutW-1:0]  TimeoutRst  = 16'd500;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [RateW-1:0]  gyro_rate;
    logic signed [RateW-1:0]  icp_rate;
    logic [VarW-1:0]          pose_variance_in;
    logic [VarW-1:0]          twist_variance_in;
  } in_t;

  typedef struct packed {
    logic [VarW-1:0] pose_variance_out;
    logic [VarW-1:0] twist_variance_out;
    logic            passed_through;
    logic            spin_excess_seen;
  } out_t;

  typedef struct packed {
    logic [GainW-1:0]     gain;
    logic [DeadbandW-1:0] deadband;
    logic [VarW-1:0]      floor;
    logic [VarW-1:0]      ceiling;
    logic                 adjust_twist;
    logic [TimeoutW-1:0]  timeout;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_GYRO,
    CMD_ODOM
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e               kind;
    logic signed [RateW-1:0] rate;
    logic [VarW-1:0]         pose;
    logic [VarW-1:0]         twist;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/gyvi_front.sv
// Front end: takes input beats, decodes the op and builds a queue command.
// Depends on gyvi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gyvi_front (
  input  wire logic          in_valid_i,
  input  wire gyvi_pkg::in_t in_data_i,
  input  wire logic          q_full_i,
  output logic               in_stall_o,
  output logic               push_o,
  output gyvi_pkg::cmd_t     cmd_o
);

  logic known;

  assign in_stall_o = q_full_i;

  always_comb begin
    known       = 1'b1;
    cmd_o.kind  = gyvi_pkg::CMD_TICK;
    cmd_o.rate  = in_data_i.icp_rate;
    cmd_o.pose  = in_data_i.pose_variance_in;
    cmd_o.twist = in_data_i.twist_variance_in;
    case (in_data_i.op)
      gyvi_pkg::OP_TICK: begin
        cmd_o.kind = gyvi_pkg::CMD_TICK;
      end
      gyvi_pkg::OP_GYRO: begin
        cmd_o.kind = gyvi_pkg::CMD_GYRO;
        cmd_o.rate = in_data_i.gyro_rate;
      end
      gyvi_pkg::OP_ODOM: begin
        cmd_o.kind = gyvi_pkg::CMD_ODOM;
      end
      default: begin
        // unused op: accepted and dropped
        known = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && !q_full_i && known;

endmodule

`default_nettype wire

// File: sv/gyvi_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on gyvi_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module gyvi_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire gyvi_pkg::cmd_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output gyvi_pkg::cmd_t      data_o
);

  localparam int unsigned Depth = gyvi_pkg::CmdQDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  gyvi_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/gyvi_back.sv
// Back end: gyro window state, serial mean divider, excess, square and
// variance inflation with a one-deep result register. Depends on gyvi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gyvi_back #(
  parameter int unsigned MaxWindow = 1023
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire gyvi_pkg::cfg_t cfg_i,
  input  wire logic           cmd_valid_i,
  input  wire gyvi_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output gyvi_pkg::out_t      out_data_o
);

  localparam int unsigned RateW  = gyvi_pkg::RateW;
  localparam int unsigned VarW   = gyvi_pkg::VarW;
  localparam int unsigned CntW   = $clog2(MaxWindow + 1);
  localparam int unsigned SumW   = RateW + CntW;
  localparam int unsigned IterW  = $clog2(SumW);
  localparam int unsigned DiffW  = RateW + 1;
  localparam int unsigned ExtraW = gyvi_pkg::GainW + DiffW;
  localparam logic [CntW-1:0]     CountMax = CntW'(MaxWindow);
  localparam logic [IterW-1:0]    IterLast = IterW'(SumW - 1);
  localparam logic [gyvi_pkg::TimeoutW-1:0] AgeMax = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } state_e;

  state_e                         state_q;
  logic signed [SumW-1:0]         sum_q;
  logic [CntW-1:0]                count_q;
  logic signed [RateW-1:0]        last_avg_q;
  logic                           seen_q;
  logic [gyvi_pkg::TimeoutW-1:0]  age_q;
  logic [SumW-1:0]                dq_q;
  logic [CntW:0]                  rem_q;
  logic [CntW-1:0]                divisor_q;
  logic                           neg_q;
  logic [IterW-1:0]               iter_q;
  logic signed [RateW-1:0]        avg_q;
  logic signed [RateW-1:0]        icp_q;
  logic [VarW-1:0]                pose_q, twist_q;
  logic [DiffW-1:0]               excess_q;
  logic [ExtraW-1:0]              extra_q;
  logic [VarW-1:0]                sq_q;
  logic                           passed_q;
  logic                           out_valid_q;
  gyvi_pkg::out_t                 out_q;

  logic                   fresh;
  logic [SumW-1:0]        rate_ext;
  logic [SumW-1:0]        sum_mag;
  logic [CntW:0]          rem_shift, rem_sub;
  logic                   rem_ge;
  logic [SumW-1:0]        dq_next;
  logic [RateW-1:0]       quot;
  logic [RateW-1:0]       avg_next;
  logic [DiffW-1:0]       diff, abs_diff, excess_next;
  logic [ExtraW-1:0]      extra_next;
  logic [2*VarW-1:0]      sq_full;
  logic                   huge;
  logic                   out_free;
  logic                   fin_fire;

  function automatic logic [VarW-1:0] inflate(
    input logic [VarW-1:0] base,
    input logic [VarW-1:0] sq,
    input logic            big,
    input logic [VarW-1:0] floor_v,
    input logic [VarW-1:0] ceil_v
  );
    logic [VarW-1:0] b;
    logic [VarW:0]   s;
    b = (base < floor_v) ? floor_v : base;
    s = {1'b0, b} + {1'b0, sq};
    if (big) begin
      return ceil_v;
    end
    return (s > {1'b0, ceil_v}) ? ceil_v : s[VarW-1:0];
  endfunction

  always_comb begin
    fresh     = seen_q && (age_q <= cfg_i.timeout);
    rate_ext  = {{CntW{cmd_i.rate[RateW-1]}}, cmd_i.rate};
    sum_mag   = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
    rem_shift = {rem_q[CntW-1:0], dq_q[SumW-1]};
    rem_ge    = (rem_shift >= {1'b0, divisor_q});
    rem_sub   = rem_shift - {1'b0, divisor_q};
    dq_next   = {dq_q[SumW-2:0], rem_ge};
    quot      = dq_next[RateW-1:0];
    // the mean of 24-bit samples always fits 24 bits signed
    avg_next  = neg_q ? RateW'(-quot) : quot;
    diff      = {avg_q[RateW-1], avg_q} - {icp_q[RateW-1], icp_q};
    abs_diff  = diff[DiffW-1] ? DiffW'(-diff) : diff;
    excess_next = (abs_diff > DiffW'(cfg_i.deadband))
                ? abs_diff - DiffW'(cfg_i.deadband) : '0;
    extra_next = ExtraW'(cfg_i.gain) * ExtraW'(excess_q);
    sq_full    = extra_q[VarW-1:0] * extra_q[VarW-1:0];
    huge       = |extra_q[ExtraW-1:VarW];
    out_free   = !out_valid_q || !out_stall_i;
    fin_fire   = (state_q == ST_FIN) && out_free;
  end

  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      last_avg_q  <= '0;
      seen_q      <= 1'b0;
      age_q       <= '0;
      dq_q        <= '0;
      rem_q       <= '0;
      divisor_q   <= '0;
      neg_q       <= 1'b0;
      iter_q      <= '0;
      avg_q       <= '0;
      icp_q       <= '0;
      pose_q      <= '0;
      twist_q     <= '0;
      excess_q    <= '0;
      extra_q     <= '0;
      sq_q        <= '0;
      passed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // result register: loaded from the last step, emptied when taken
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.kind)
              gyvi_pkg::CMD_TICK: begin
                if (age_q != AgeMax) begin
                  age_q <= age_q + gyvi_pkg::TimeoutW'(1);
                end
              end
              gyvi_pkg::CMD_GYRO: begin
                if (count_q < CountMax) begin
                  sum_q   <= sum_q + $signed(rate_ext);
                  count_q <= count_q + CntW'(1);
                end
                seen_q <= 1'b1;
                age_q  <= '0;
              end
              gyvi_pkg::CMD_ODOM: begin
                icp_q   <= cmd_i.rate;
                pose_q  <= cmd_i.pose;
                twist_q <= cmd_i.twist;
                sum_q   <= '0;
                count_q <= '0;
                if (!fresh) begin
                  passed_q <= 1'b1;
                  excess_q <= '0;
                  state_q  <= ST_FIN;
                end else begin
                  passed_q <= 1'b0;
                  if (count_q != '0) begin
                    dq_q      <= sum_mag;
                    rem_q     <= '0;
                    divisor_q <= count_q;
                    neg_q     <= sum_q[SumW-1];
                    iter_q    <= IterLast;
                    state_q   <= ST_DIV;
                  end else begin
                    avg_q   <= last_avg_q;
                    state_q <= ST_DIFF;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          dq_q  <= dq_next;
          rem_q <= rem_ge ? rem_sub : rem_shift;
          if (iter_q == '0) begin
            avg_q      <= avg_next;
            last_avg_q <= avg_next;
            state_q    <= ST_DIFF;
          end else begin
            iter_q <= iter_q - IterW'(1);
          end
        end
        ST_DIFF: begin
          excess_q <= excess_next;
          state_q  <= ST_MUL;
        end
        ST_MUL: begin
          extra_q <= extra_next;
          state_q <= ST_SQR;
        end
        ST_SQR: begin
          sq_q    <= sq_full[2*VarW-1:VarW];
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_q.passed_through   <= passed_q;
            out_q.spin_excess_seen <= (excess_q != '0);
            out_q.pose_variance_out <= passed_q ? pose_q
                : inflate(pose_q, sq_q, huge, cfg_i.floor, cfg_i.ceiling);
            out_q.twist_variance_out <= (passed_q || !cfg_i.adjust_twist) ? twist_q
                : inflate(twist_q, sq_q, huge, cfg_i.floor, cfg_i.ceiling);
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/gyro_gated_yaw_variance_inflator.sv
// Gyro-gated yaw variance inflator: top level with configuration registers.
// Instantiates gyvi_front, gyvi_cmd_fifo and gyvi_back; uses gyvi_pkg.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_data_i): one beat per item.
//   Op tick ages the gyro, op gyro adds a sample to the window, op odometry
//   produces one result beat; the unused op code is taken and dropped.
// - Output channel (out_valid_o / out_stall_i / out_data_o): one beat per
//   odometry item, in order, from a one-deep result register.
// - Config channel (cfg_valid_i / cfg_ready_o, index + data): always ready;
//   write only while the block is idle. Unknown indexes are ignored.
// - Ticks and gyro samples are handled in the back end's idle state. An odometry
//   item with a non-empty window goes through the one-bit-a-cycle restoring
//   divider for the window mean, then the difference, multiply, square and
//   final steps; a stale item goes straight to the final step and an
//   empty-window item skips the divider. A two-entry command queue decouples
//   the input from the back end, so input is taken while the back end works.
// - A stalled output holds the back end in its last step; the queue then
//   fills and in_stall_o rises. Reset clears all state and loads defaults.
`timescale 1ns / 1ps
`default_nettype none

module gyro_gated_yaw_variance_inflator #(
  parameter int unsigned MAX_WINDOW_SAMPLES = 1023
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire gyvi_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output gyvi_pkg::out_t                        out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [gyvi_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [gyvi_pkg::CfgDataW-1:0]    cfg_data_i
);

  gyvi_pkg::cfg_t cfg_q;
  gyvi_pkg::cmd_t front_cmd, q_cmd;
  logic           push, q_full, q_valid, q_pop;

  // Config registers: always ready, written straight from the port.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain         <= gyvi_pkg::GainRst;
      cfg_q.deadband     <= gyvi_pkg::DeadbandRst;
      cfg_q.floor        <= gyvi_pkg::FloorRst;
      cfg_q.ceiling      <= gyvi_pkg::CeilingRst;
      cfg_q.adjust_twist <= gyvi_pkg::AdjTwistRst;
      cfg_q.timeout      <= gyvi_pkg::TimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gyvi_pkg::CFG_GAIN:         cfg_q.gain         <= cfg_data_i[gyvi_pkg::GainW-1:0];
        gyvi_pkg::CFG_DEADBAND:     cfg_q.deadband     <= cfg_data_i[gyvi_pkg::DeadbandW-1:0];
        gyvi_pkg::CFG_FLOOR:        cfg_q.floor        <= cfg_data_i[gyvi_pkg::VarW-1:0];
        gyvi_pkg::CFG_CEILING:      cfg_q.ceiling      <= cfg_data_i[gyvi_pkg::VarW-1:0];
        gyvi_pkg::CFG_ADJUST_TWIST: cfg_q.adjust_twist <= cfg_data_i[0];
        gyvi_pkg::CFG_TIMEOUT:      cfg_q.timeout      <= cfg_data_i[gyvi_pkg::TimeoutW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: decode and push into the queue.
  gyvi_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  gyvi_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_cmd)
  );

  // Back end: window state, divider, inflation and result register.
  gyvi_back #(
    .MaxWindow (MAX_WINDOW_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: verif/tb_gyro_gated_yaw_variance_inflator.sv
`timescale 1ns / 1ps
// Self-checking bench for gyro_gated_yaw_variance_inflator: directed corners,
// a window fill past its cap, then random gyro/odometry frames under several settings.
// Depends on gyvi_pkg and the block's RTL only; a scoreboard class predicts every result beat.

module tb_gyro_gated_yaw_variance_inflator;

  localparam int unsigned WindowCap   = 1023;
  localparam int unsigned DrainCycles = 120;   // well over the slowest odometry item
  localparam int unsigned ReportLimit = 10;
  localparam int          RateMax     = 8388607;
  localparam int          RateMin     = -8388608;
  localparam logic [1:0]  OpSpare     = 2'd3;  // unused op code, dropped by the block

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the window, gyro age and settings, works
  // out the variances each odometry beat should produce and checks them in order.
  // ---------------------------------------------------------------------------
  class variance_scoreboard;
    logic [gyvi_pkg::GainW-1:0]     gain;
    logic [gyvi_pkg::DeadbandW-1:0] band;
    logic [gyvi_pkg::VarW-1:0]      var_floor;
    logic [gyvi_pkg::VarW-1:0]      var_ceiling;
    logic                           twist_on;
    logic [gyvi_pkg::TimeoutW-1:0]  timeout_ticks;

    longint          rate_sum;
    int unsigned     rate_count;
    int              held_mean;
    bit              gyro_seen;
    logic [15:0]     gyro_age;

    gyvi_pkg::out_t  awaited_variances[$];
    int unsigned     faults;

    function new();
      gain          = gyvi_pkg::GainRst;
      band          = gyvi_pkg::DeadbandRst;
      var_floor     = gyvi_pkg::FloorRst;
      var_ceiling   = gyvi_pkg::CeilingRst;
      twist_on      = gyvi_pkg::AdjTwistRst;
      timeout_ticks = gyvi_pkg::TimeoutRst;
      rate_sum      = 0;
      rate_count    = 0;
      held_mean     = 0;
      gyro_seen     = 1'b0;
      gyro_age      = '0;
      faults        = 0;
    endfunction

    function void write_reg(logic [gyvi_pkg::CfgIdxW-1:0] idx,
                            logic [gyvi_pkg::CfgDataW-1:0] data);
      case (idx)
        gyvi_pkg::CFG_GAIN:         gain          = data[gyvi_pkg::GainW-1:0];
        gyvi_pkg::CFG_DEADBAND:     band          = data[gyvi_pkg::DeadbandW-1:0];
        gyvi_pkg::CFG_FLOOR:        var_floor     = data;
        gyvi_pkg::CFG_CEILING:      var_ceiling   = data;
        gyvi_pkg::CFG_ADJUST_TWIST: twist_on      = data[0];
        gyvi_pkg::CFG_TIMEOUT:      timeout_ticks = data[gyvi_pkg::TimeoutW-1:0];
        default: ;
      endcase
    endfunction

    // floor first, then the squared term, ceiling last so it wins over the floor
    function logic [gyvi_pkg::VarW-1:0] inflate_variance(logic [gyvi_pkg::VarW-1:0] base,
                                                         bit [63:0] extra, bit huge);
      bit [63:0] lifted;
      lifted = (base < var_floor) ? 64'(var_floor) : 64'(base);
      if (huge) return var_ceiling;
      lifted += (extra * extra) >> 32;
      return (lifted > 64'(var_ceiling)) ? var_ceiling : lifted[gyvi_pkg::VarW-1:0];
    endfunction

    function void take_item(gyvi_pkg::in_t item);
      longint         mean;
      longint         diff;
      longint         excess;
      bit [63:0]      extra;
      bit             huge;
      gyvi_pkg::out_t res;
      case (item.op)
        gyvi_pkg::OP_TICK: begin
          if (gyro_age != 16'hFFFF) gyro_age++;
        end
        gyvi_pkg::OP_GYRO: begin
          if (rate_count < WindowCap) begin
            rate_sum += longint'($signed(item.gyro_rate));
            rate_count++;
          end
          gyro_seen = 1'b1;
          gyro_age  = '0;
        end
        gyvi_pkg::OP_ODOM: begin
          if (!(gyro_seen && gyro_age <= timeout_ticks)) begin
            // stale gyro: copy through, drop the window, keep the held mean
            rate_sum   = 0;
            rate_count = 0;
            res.pose_variance_out  = item.pose_variance_in;
            res.twist_variance_out = item.twist_variance_in;
            res.passed_through     = 1'b1;
            res.spin_excess_seen   = 1'b0;
          end else begin
            mean       = (rate_count > 0) ? rate_sum / longint'(rate_count) : held_mean;
            held_mean  = int'(mean);
            rate_sum   = 0;
            rate_count = 0;
            diff = mean - longint'($signed(item.icp_rate));
            if (diff < 0) diff = -diff;
            excess = (diff > longint'(band)) ? diff - longint'(band) : 0;
            extra  = 64'(gain) * 64'(excess);
            huge   = (extra >= 64'h1_0000_0000);
            res.pose_variance_out  = inflate_variance(item.pose_variance_in, extra, huge);
            res.twist_variance_out = twist_on ?
                                     inflate_variance(item.twist_variance_in, extra, huge) :
                                     item.twist_variance_in;
            res.passed_through     = 1'b0;
            res.spin_excess_seen   = (excess > 0);
          end
          awaited_variances.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_variances(gyvi_pkg::out_t got);
      gyvi_pkg::out_t want;
      if (awaited_variances.size() == 0) begin
        faults++;
        if (faults <= ReportLimit)
          $display("unexpected result beat: pose %h twist %h pass %b spin %b",
                   got.pose_variance_out, got.twist_variance_out,
                   got.passed_through, got.spin_excess_seen);
        return;
      end
      want = awaited_variances.pop_front();
      if (got.pose_variance_out  !== want.pose_variance_out  ||
          got.twist_variance_out !== want.twist_variance_out ||
          got.passed_through     !== want.passed_through     ||
          got.spin_excess_seen   !== want.spin_excess_seen) begin
        faults++;
        if (faults <= ReportLimit)
          $display({"mismatch: exp pose %h twist %h pass %b spin %b",
                    " | got pose %h twist %h pass %b spin %b"},
                   want.pose_variance_out, want.twist_variance_out,
                   want.passed_through, want.spin_excess_seen,
                   got.pose_variance_out, got.twist_variance_out,
                   got.passed_through, got.spin_excess_seen);
      end
    endfunction

    function int unsigned pending();
      return awaited_variances.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's ports; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  gyvi_pkg::in_t                 in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  gyvi_pkg::out_t                out_data_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [gyvi_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [gyvi_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  bit in_idling  = 1'b0;   // sender gaps between beats
  bit out_idling = 1'b0;   // receiver stall bursts

  variance_scoreboard sb;

  gyro_gated_yaw_variance_inflator #(
    .MAX_WINDOW_SAMPLES(WindowCap)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Generous simulation-time guard; a correct run needs well under a millisecond.
  initial begin
    #20_000_000;
    $display("gyro_gated_yaw_variance_inflator verification failed");
    $finish;
  end

  // Receiver: random stall bursts while idling is enabled.
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_idling && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result monitor: pre-edge values decide whether a beat was taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_variances(out_data_o);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic gyvi_pkg::in_t make_item(logic [1:0] op, int gyro, int icp,
                                              logic [gyvi_pkg::VarW-1:0] pose,
                                              logic [gyvi_pkg::VarW-1:0] twist);
    gyvi_pkg::in_t it;
    it.op                = op;
    it.gyro_rate         = gyro[gyvi_pkg::RateW-1:0];
    it.icp_rate          = icp[gyvi_pkg::RateW-1:0];
    it.pose_variance_in  = pose;
    it.twist_variance_in = twist;
    return it;
  endfunction

  // mostly moderate rates, with full-range values and the two extremes mixed in
  function automatic int rand_rate();
    logic signed [gyvi_pkg::RateW-1:0] r;
    case ($urandom_range(0, 3))
      0:       r = 24'($urandom());
      1:       r = $urandom_range(0, 1) ? 24'(RateMax) : 24'(RateMin);
      default: r = 24'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
    return int'(r);
  endfunction

  // variances clustered round the current floor and ceiling as well as spread wide
  function automatic logic [gyvi_pkg::VarW-1:0] rand_var();
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      2:       return sb.var_floor + 32'($urandom_range(0, 8)) - 32'd4;
      3:       return sb.var_ceiling - 32'($urandom_range(0, 1 << 12));
      default: return 32'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  // a register value of the given width: zero, all ones, or random
  function automatic logic [gyvi_pkg::CfgDataW-1:0] pick_field(int unsigned w);
    longint unsigned mask;
    mask = (64'd1 << w) - 1;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 32'(mask);
      default: return 32'(longint'($urandom()) & mask);
    endcase
  endfunction

  // Holds valid high across back-to-back beats; lowers it only for a gap.
  task automatic send_item(gyvi_pkg::in_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_item(it);
    if (in_idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [gyvi_pkg::CfgIdxW-1:0] idx,
                           logic [gyvi_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic write_settings(logic [gyvi_pkg::GainW-1:0] gain,
                                logic [gyvi_pkg::DeadbandW-1:0] band,
                                logic [gyvi_pkg::VarW-1:0] lo, logic [gyvi_pkg::VarW-1:0] hi,
                                logic adj, logic [gyvi_pkg::TimeoutW-1:0] tmo);
    write_reg(gyvi_pkg::CFG_GAIN,         32'(gain));
    write_reg(gyvi_pkg::CFG_DEADBAND,     32'(band));
    write_reg(gyvi_pkg::CFG_FLOOR,        lo);
    write_reg(gyvi_pkg::CFG_CEILING,      hi);
    write_reg(gyvi_pkg::CFG_ADJUST_TWIST, 32'(adj));
    write_reg(gyvi_pkg::CFG_TIMEOUT,      32'(tmo));
    cfg_valid_i <= 1'b0;
  endtask

  // Idle point: all results in, then time for trailing ticks and gyro beats to drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random frames: a few gyro samples near a centre rate, some ticks (sometimes
  // enough to go stale), then one odometry beat; now and then a stray beat.
  task automatic run_frames(int unsigned budget);
    int unsigned sent;
    int unsigned n_gyro;
    int unsigned n_tick;
    int          centre;
    int          spread;
    int          mean;
    int          icp;
    logic [1:0]  op;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 11) == 0) begin
        op = 2'($urandom_range(0, 3));
        send_item(make_item(op, rand_rate(), rand_rate(), rand_var(), rand_var()));
        if (op != OpSpare) sent++;
      end
      centre = rand_rate();
      spread = 1 << $urandom_range(0, 16);
      n_gyro = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0)
        n_tick = (sb.timeout_ticks > 40) ? 40 : sb.timeout_ticks + $urandom_range(0, 2);
      else
        n_tick = $urandom_range(0, 3);
      repeat (n_gyro) begin
        send_item(make_item(gyvi_pkg::OP_GYRO,
                            centre + int'($urandom_range(0, 2 * spread)) - spread,
                            rand_rate(), $urandom(), $urandom()));
      end
      repeat (n_tick) begin
        send_item(make_item(gyvi_pkg::OP_TICK, rand_rate(), rand_rate(),
                            $urandom(), $urandom()));
      end
      // aim the odometry rate at the predicted mean so the deadband edge gets hit
      mean = (sb.rate_count > 0) ? int'(sb.rate_sum / longint'(sb.rate_count)) : sb.held_mean;
      case ($urandom_range(0, 3))
        0:       icp = rand_rate();
        1:       icp = mean + ($urandom_range(0, 1) ? 1 : -1) *
                       (int'(sb.band) + int'($urandom_range(0, 2)) - 1);
        default: icp = mean + int'($urandom_range(0, 2 * spread)) - spread;
      endcase
      send_item(make_item(gyvi_pkg::OP_ODOM, rand_rate(), icp, rand_var(), rand_var()));
      sent += n_gyro + n_tick + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset; no gyro yet so the first odometry beat passes through
    send_item(make_item(gyvi_pkg::OP_ODOM, 0, 0, 32'hFFFF_FFFF, 32'h0));
    send_item(make_item(OpSpare, RateMax, RateMin, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // mean of the two extremes is minus a half, truncated towards zero
    send_item(make_item(gyvi_pkg::OP_GYRO, RateMax, 0, 0, 0));
    send_item(make_item(gyvi_pkg::OP_GYRO, RateMin, 0, 0, 0));
    send_item(make_item(gyvi_pkg::OP_ODOM, 0, 0, 32'h0001_0000, 32'h0000_8000));
    // widest disagreement saturates the squared term
    send_item(make_item(gyvi_pkg::OP_GYRO, RateMax, 0, 0, 0));
    send_item(make_item(gyvi_pkg::OP_ODOM, 0, RateMin, 32'h0, 32'h0));
    // empty window while fresh reuses the held mean
    send_item(make_item(gyvi_pkg::OP_ODOM, 0, RateMax, 32'h100, 32'h200));
    send_item(make_item(gyvi_pkg::OP_GYRO, -3, 0, 0, 0));
    send_item(make_item(gyvi_pkg::OP_GYRO, -4, 0, 0, 0));
    send_item(make_item(gyvi_pkg::OP_ODOM, 0, 100000, 32'h8000, 32'h4000));
    repeat (3) send_item(make_item(gyvi_pkg::OP_TICK, 0, 0, 0, 0));
    send_item(make_item(gyvi_pkg::OP_ODOM, 0, -20000, 32'h1234, 32'h5678));
    settle();

    // ceiling below floor, twist left alone, zero timeout, largest gain
    write_settings(16'hFFFF, 23'd0, 32'h0010_0000, 32'h0008_0000, 1'b0, 16'd0);
    send_item(make_item(gyvi_pkg::OP_GYRO, 1000, 0, 0, 0));
    send_item(make_item(gyvi_pkg::OP_ODOM, 0, 0, 32'd5, 32'd7));
    send_item(make_item(gyvi_pkg::OP_TICK, 0, 0, 0, 0));
    send_item(make_item(gyvi_pkg::OP_ODOM, 0, 0, 32'd5, 32'd7));
    settle();

    // fill the window past its cap; the late samples must be left out
    write_settings(16'd1, 23'd0, 32'h0, 32'hFFFF_FFFF, 1'b1, 16'd500);
    repeat (WindowCap) send_item(make_item(gyvi_pkg::OP_GYRO, RateMin, 0, 0, 0));
    repeat (7) send_item(make_item(gyvi_pkg::OP_GYRO, RateMax, 0, 0, 0));
    send_item(make_item(gyvi_pkg::OP_ODOM, 0, RateMin, 32'h40, 32'h80));
    settle();

    // random phases: all-low and all-high settings first, last phase without idling
    for (int phase = 0; phase < 8; phase++) begin
      in_idling  = (phase < 7);
      out_idling = (phase < 7);
      if (phase == 0)
        write_settings('0, '0, '0, '0, 1'b0, '0);
      else if (phase == 1)
        write_settings('1, '1, '1, '1, 1'b1, '1);
      else
        write_settings(16'(pick_field(gyvi_pkg::GainW)), 23'(pick_field(gyvi_pkg::DeadbandW)),
                       pick_field(gyvi_pkg::VarW), pick_field(gyvi_pkg::VarW),
                       1'($urandom_range(0, 1)),
                       ($urandom_range(0, 3) == 0) ? 16'(pick_field(gyvi_pkg::TimeoutW)) :
                                                     16'($urandom_range(0, 30)));
      run_frames(12);
      settle();
    end

    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("gyro_gated_yaw_variance_inflator verification clean");
    end else begin
      $display("gyro_gated_yaw_variance_inflator verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/gyvi_pkg.sv
sv/gyvi_front.sv
sv/gyvi_cmd_fifo.sv
sv/gyvi_back.sv
sv/gyro_gated_yaw_variance_inflator.sv
verif/tb_gyro_gated_yaw_variance_inflator.sv
